### rtl/servo_command_packet_framer_macros.svh
// Assertion macros used by the servo command packet framer checker.
`ifndef SERVO_COMMAND_PACKET_FRAMER_MACROS_SVH
`define SERVO_COMMAND_PACKET_FRAMER_MACROS_SVH

// Same-cycle implication, sampled on clk, idle while arst_n is low.
`define SCPF_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, idle while arst_n is low.
`define SCPF_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/scpf_pkg.sv
// Types and constants of the servo command packet framer.
package scpf_pkg;

	localparam logic [7:0] HDR_BYTE     = 8'h55;
	localparam logic [7:0] LEN_BIAS     = 8'd3;
	localparam int         PARAM_FIELDS = 6;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_HDR0,
		ST_HDR1,
		ST_ID,
		ST_LEN,
		ST_CMD,
		ST_PARAM
	} state_t;

	typedef enum logic [2:0] {
		SEL_HDR,
		SEL_ID,
		SEL_LEN,
		SEL_CMD,
		SEL_PARAM,
		SEL_CSUM
	} byte_sel_t;

	typedef struct packed {
		logic      load;
		logic      emit;
		byte_sel_t sel;
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;
		logic params_left;
	} dp_status_t;

endpackage

### rtl/scpf_if.sv
// Handshake interfaces for the command input and the byte output.
interface scpf_cmd_if;
	logic       valid;
	logic       ready;
	logic [7:0] device_id;
	logic [7:0] command;
	logic [2:0] param_count;
	logic [7:0] param_0;
	logic [7:0] param_1;
	logic [7:0] param_2;
	logic [7:0] param_3;
	logic [7:0] param_4;
	logic [7:0] param_5;

	modport source (
		output valid, device_id, command, param_count,
		output param_0, param_1, param_2, param_3, param_4, param_5,
		input  ready
	);
	modport sink (
		input  valid, device_id, command, param_count,
		input  param_0, param_1, param_2, param_3, param_4, param_5,
		output ready
	);
endinterface

interface scpf_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] tx_byte;
	logic       last_byte;

	modport source (output valid, tx_byte, last_byte, input ready);
	modport sink (input valid, tx_byte, last_byte, output ready);
endinterface

### rtl/servo_command_packet_framer.sv
// After a command is taken, the first header word enters the output register when free.
// Throughput, set by the single output register: one word per cycle unless the output
// stalls; a command with N parameters gives 6 + N words after an accept step in ST_IDLE.
// The next command is taken while the checksum word still waits at the output.
// Reset (arst_n low, asynchronous): sequencer idle, output empty, sum and index cleared.
module servo_command_packet_framer #(
	parameter int MAX_PARAMS = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	scpf_cmd_if.sink    cmd,
	scpf_byte_if.source tx
);

	scpf_pkg::dp_cmd_t    dp_cmd;
	scpf_pkg::dp_status_t dp_status;
	logic                 in_ready;

	scpf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cmd.valid),
		.in_ready  (in_ready),
		.dp_status (dp_status),
		.dp_cmd    (dp_cmd)
	);

	scpf_dp #(
		.MAX_PARAMS (MAX_PARAMS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.tx        (tx),
		.dp_cmd    (dp_cmd),
		.dp_status (dp_status)
	);

	assign cmd.ready = in_ready;

endmodule

### rtl/scpf_dp.sv
// Datapath: held command fields, checksum accumulator and output word register.
module scpf_dp #(
	parameter int MAX_PARAMS = 6
) (
	input  logic                  clk,
	input  logic                  arst_n,
	scpf_cmd_if.sink              cmd,
	scpf_byte_if.source           tx,
	input  scpf_pkg::dp_cmd_t     dp_cmd,
	output scpf_pkg::dp_status_t  dp_status
);

	localparam int CNT_W = $clog2(MAX_PARAMS + 1);
	localparam int IDX_W = (MAX_PARAMS > 1) ? $clog2(MAX_PARAMS) : 1;

	logic [7:0]       id_q;
	logic [7:0]       cmd_q;
	logic [CNT_W-1:0] count_q;
	logic [7:0]       params_q [MAX_PARAMS];
	logic [CNT_W-1:0] idx_q;
	logic [7:0]       sum_q;
	logic [7:0]       byte_q;
	logic             last_q;
	logic             valid_q;

	logic [7:0]       params_in [scpf_pkg::PARAM_FIELDS];
	logic [CNT_W-1:0] count_sat;
	logic [7:0]       byte_d;
	logic             add_d;

	always_comb begin
		params_in[0] = cmd.param_0;
		params_in[1] = cmd.param_1;
		params_in[2] = cmd.param_2;
		params_in[3] = cmd.param_3;
		params_in[4] = cmd.param_4;
		params_in[5] = cmd.param_5;
	end

	// clamp an oversized count to the parameter limit
	assign count_sat = (cmd.param_count > 3'(MAX_PARAMS)) ? CNT_W'(MAX_PARAMS)
		: CNT_W'(cmd.param_count);

	always_comb begin
		byte_d = '0;
		add_d  = 1'b0;
		unique case (dp_cmd.sel)
			scpf_pkg::SEL_HDR: begin
				byte_d = scpf_pkg::HDR_BYTE;
			end
			scpf_pkg::SEL_ID: begin
				byte_d = id_q;
				add_d  = 1'b1;
			end
			scpf_pkg::SEL_LEN: begin
				byte_d = 8'(count_q) + scpf_pkg::LEN_BIAS;
				add_d  = 1'b1;
			end
			scpf_pkg::SEL_CMD: begin
				byte_d = cmd_q;
				add_d  = 1'b1;
			end
			scpf_pkg::SEL_PARAM: begin
				byte_d = params_q[idx_q[IDX_W-1:0]];
				add_d  = 1'b1;
			end
			scpf_pkg::SEL_CSUM: begin
				byte_d = ~sum_q;
			end
			default: begin
				byte_d = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (dp_cmd.load) begin
			id_q    <= cmd.device_id;
			cmd_q   <= cmd.command;
			count_q <= count_sat;
			for (int i = 0; i < MAX_PARAMS; i++) begin
				params_q[i] <= params_in[i];
			end
		end
		if (dp_cmd.emit) begin
			byte_q <= byte_d;
			last_q <= (dp_cmd.sel == scpf_pkg::SEL_CSUM);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			sum_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (dp_cmd.load) begin
				idx_q <= '0;
				sum_q <= '0;
			end else if (dp_cmd.emit) begin
				if (add_d) begin
					sum_q <= sum_q + byte_d;
				end
				if (dp_cmd.sel == scpf_pkg::SEL_PARAM) begin
					idx_q <= idx_q + 1'b1;
				end
			end
			if (dp_cmd.emit) begin
				valid_q <= 1'b1;
			end else if (tx.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	assign tx.valid     = valid_q;
	assign tx.tx_byte   = byte_q;
	assign tx.last_byte = last_q;

	assign dp_status.out_free    = !valid_q || tx.ready;
	assign dp_status.params_left = (idx_q < count_q);

endmodule

### rtl/scpf_ctrl.sv
// Controller: sequences the packet fields into the output word register.
module scpf_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  scpf_pkg::dp_status_t  dp_status,
	output scpf_pkg::dp_cmd_t     dp_cmd
);

	scpf_pkg::state_t state_q;
	scpf_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= scpf_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		in_ready    = 1'b0;
		dp_cmd.load = 1'b0;
		dp_cmd.emit = 1'b0;
		dp_cmd.sel  = scpf_pkg::SEL_HDR;
		unique case (state_q)
			scpf_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					dp_cmd.load = 1'b1;
					state_d     = scpf_pkg::ST_HDR0;
				end
			end
			scpf_pkg::ST_HDR0: begin
				if (dp_status.out_free) begin
					dp_cmd.emit = 1'b1;
					state_d     = scpf_pkg::ST_HDR1;
				end
			end
			scpf_pkg::ST_HDR1: begin
				if (dp_status.out_free) begin
					dp_cmd.emit = 1'b1;
					state_d     = scpf_pkg::ST_ID;
				end
			end
			scpf_pkg::ST_ID: begin
				dp_cmd.sel = scpf_pkg::SEL_ID;
				if (dp_status.out_free) begin
					dp_cmd.emit = 1'b1;
					state_d     = scpf_pkg::ST_LEN;
				end
			end
			scpf_pkg::ST_LEN: begin
				dp_cmd.sel = scpf_pkg::SEL_LEN;
				if (dp_status.out_free) begin
					dp_cmd.emit = 1'b1;
					state_d     = scpf_pkg::ST_CMD;
				end
			end
			scpf_pkg::ST_CMD: begin
				dp_cmd.sel = scpf_pkg::SEL_CMD;
				if (dp_status.out_free) begin
					dp_cmd.emit = 1'b1;
					state_d     = scpf_pkg::ST_PARAM;
				end
			end
			scpf_pkg::ST_PARAM: begin
				// send parameters while any remain, then the checksum word
				dp_cmd.sel = dp_status.params_left ? scpf_pkg::SEL_PARAM
					: scpf_pkg::SEL_CSUM;
				if (dp_status.out_free) begin
					dp_cmd.emit = 1'b1;
					if (!dp_status.params_left) begin
						state_d = scpf_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = scpf_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

### rtl/scpf_checker.sv
// Port-level checker for the servo command packet framer and its bind.
`include "servo_command_packet_framer_macros.svh"

module scpf_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] tx_byte,
	input logic       last_byte
);

	`SCPF_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(tx_byte) && $stable(last_byte), "stalled output word changed")
	`SCPF_ASSERT_NXT(a_busy_after_take, in_valid && in_ready, !in_ready, "command taken while a packet is starting")
	`SCPF_ASSERT_IMP(a_ready_on_csum, $rose(in_ready), out_valid && last_byte, "input reopened before the checksum word")
	`SCPF_ASSERT_IMP(a_mid_packet_busy, out_valid && !last_byte, !in_ready, "input open in the middle of a packet")

endmodule

bind servo_command_packet_framer scpf_checker u_scpf_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (cmd.valid),
	.in_ready  (cmd.ready),
	.out_valid (tx.valid),
	.out_ready (tx.ready),
	.tx_byte   (tx.tx_byte),
	.last_byte (tx.last_byte)
);
